// File: rtl/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

    localparam int MaxBlocks   = 64;
    localparam int PageBytes   = 4096;
    localparam int HeaderBytes = 16;
    localparam int AlignBytes  = 16;

    localparam logic [31:0] ResetHeapBase     = 32'h1800_0000;
    localparam logic [12:0] ResetInitialPages = 13'd4;
    localparam logic [12:0] ResetLimitPages   = 13'd4096;
    localparam int          HeapMaxBytes      = 16 * 1024 * 1024;
    localparam int          HardPageCap       = 4096;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_STATS = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_NO_MEMORY = 3'd3;
    localparam logic [2:0] ST_BAD_FREE  = 3'd4;

    localparam logic [1:0] CFG_HEAP_BASE     = 2'd0;
    localparam logic [1:0] CFG_INITIAL_PAGES = 2'd1;
    localparam logic [1:0] CFG_LIMIT_PAGES   = 2'd2;

    typedef struct packed {
        logic [24:0] heap_span;
        logic [24:0] free_sum;
        logic [24:0] used_sum;
        logic [6:0]  free_count;
        logic [6:0]  used_count;
        logic [24:0] largest_free;
    } t_stats;

endpackage

// File: rtl/ffha_stats.sv
// Statistics accumulator: one table entry per beat; sums, saturating counts and the largest free size.
module ffha_stats (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_add,
    input  logic        i_used,
    input  logic [24:0] i_size,
    output logic [24:0] o_free_sum,
    output logic [24:0] o_used_sum,
    output logic [6:0]  o_free_count,
    output logic [6:0]  o_used_count,
    output logic [24:0] o_largest
);
    logic [24:0] r_fb, r_ub, r_big;
    logic [6:0]  r_fc, r_uc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fb  <= '0;
            r_ub  <= '0;
            r_big <= '0;
            r_fc  <= '0;
            r_uc  <= '0;
        end else if (i_add) begin
            if (i_used) begin
                r_ub <= r_ub + i_size;
                if (r_uc != 7'd127) r_uc <= r_uc + 7'd1;
            end else begin
                r_fb <= r_fb + i_size;
                if (r_fc != 7'd127) r_fc <= r_fc + 7'd1;
                if (i_size > r_big) r_big <= i_size;
            end
        end
    end

    assign o_free_sum   = r_fb;
    assign o_used_sum   = r_ub;
    assign o_free_count = r_fc;
    assign o_used_count = r_uc;
    assign o_largest    = r_big;
endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator top level: block table, sequencer and channels.
//
// channel | direction | signals
// in      | in        | i_valid, o_stall, i_mode, i_request_size, i_free_address
// out     | out       | o_valid, i_stall, o_status ... o_largest_free
// cfg     | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// For a table of N blocks: scans and the closing statistics walk read each entry in
// turn; table moves for a split or a merge removal read, then write each moved entry.
// A grow extends the last free block or appends one, then repeats the scan. The worst
// item is a free that merges on both sides near the head; output stalls lengthen it.
// Reset clears control state; the table holds no value until written.
// The input stalls from acceptance until the result beat leaves the output register.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MaxBlocks,
    parameter int PAGE_BYTES   = ffha_pkg::PageBytes,
    parameter int HEADER_BYTES = ffha_pkg::HeaderBytes,
    parameter int ALIGN_BYTES  = ffha_pkg::AlignBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [24:0] i_request_size,
    input  logic [31:0] i_free_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_block_address,
    output logic [24:0] o_heap_span,
    output logic [24:0] o_free_sum,
    output logic [24:0] o_used_sum,
    output logic [6:0]  o_free_block_count,
    output logic [6:0]  o_used_block_count,
    output logic [24:0] o_largest_free,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int PSH = $clog2(PAGE_BYTES);
    localparam int ASH = $clog2(ALIGN_BYTES);
    localparam int BYSZ = ffha_pkg::HeapMaxBytes / PAGE_BYTES;
    localparam int CAPC = (BYSZ < ffha_pkg::HardPageCap) ? BYSZ : ffha_pkg::HardPageCap;
    localparam logic [12:0] SizeCap = 13'(CAPC);
    localparam logic [31:0] Hdr  = 32'(HEADER_BYTES);
    localparam logic [31:0] HdrA = 32'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FRD    = 5'd1;
    localparam logic [4:0] S_FCHK   = 5'd2;
    localparam logic [4:0] S_GROW   = 5'd3;
    localparam logic [4:0] S_GRD    = 5'd4;
    localparam logic [4:0] S_SPLIT  = 5'd5;
    localparam logic [4:0] S_SHR    = 5'd6;
    localparam logic [4:0] S_SHW    = 5'd7;
    localparam logic [4:0] S_INSW   = 5'd8;
    localparam logic [4:0] S_MARK   = 5'd9;
    localparam logic [4:0] S_DRD    = 5'd10;
    localparam logic [4:0] S_DCHK   = 5'd11;
    localparam logic [4:0] S_NRD    = 5'd12;
    localparam logic [4:0] S_NCHK   = 5'd13;
    localparam logic [4:0] S_PRD    = 5'd14;
    localparam logic [4:0] S_PCHK   = 5'd15;
    localparam logic [4:0] S_RMR    = 5'd16;
    localparam logic [4:0] S_RMW    = 5'd17;
    localparam logic [4:0] S_STRD   = 5'd18;
    localparam logic [4:0] S_STACC  = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;
    localparam logic [4:0] S_FREEW  = 5'd22;

    // entry: offset[31:0], size[31:0], used
    logic [64:0] mem [MAX_BLOCKS];
    logic        r_we;
    logic [IW-1:0] r_wa, r_ra;
    logic [64:0] r_wd, r_rd;

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[r_ra];
    end

    logic [31:0] r_heap_base;
    logic [12:0] r_init_pages, r_limit_pages;
    logic [4:0]  r_state;
    logic        r_ready;
    logic [CW-1:0] r_count;
    logic [12:0] r_pages;
    logic [1:0]  r_mode;
    logic [31:0] r_arg, r_want;
    logic [CW-1:0] r_idx, r_pos, r_pass;
    logic [64:0] r_ent;
    logic [CW-1:0] r_rm_pos;
    logic        r_grown, r_phase;
    logic [2:0]  r_status;
    logic [31:0] r_addr;
    logic [64:0] r_pend;
    logic [CW-1:0] r_after;
    logic [4:0]  r_ret;
    logic        st_clear, st_add;
    logic [24:0] fb, ub, big;
    logic [6:0]  fc, uc;

    logic [12:0] cap;
    logic [12:0] lim;
    logic [31:0] need, g_pages;
    logic [31:0] rd_off, rd_size;
    logic        rd_used;
    logic [12:0] ipages;

    assign lim    = (r_limit_pages == 13'd0) ? 13'd1 : r_limit_pages;
    assign cap    = (lim > SizeCap) ? SizeCap : lim;
    assign need   = r_want + Hdr;
    assign g_pages = (need + 32'(PAGE_BYTES - 1)) >> PSH;
    assign rd_off  = r_rd[64:33];
    assign rd_size = r_rd[32:1];
    assign rd_used = r_rd[0];
    assign ipages  = (r_init_pages == 13'd0) ? 13'd1 :
                     ((r_init_pages > cap) ? cap : r_init_pages);

    ffha_stats u_stats (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(st_clear), .i_add(st_add),
        .i_used(rd_used), .i_size(rd_size[24:0]), .o_free_sum(fb), .o_used_sum(ub),
        .o_free_count(fc), .o_used_count(uc), .o_largest(big)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign st_clear    = (r_state == S_IDLE);
    assign st_add      = (r_state == S_STACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= ffha_pkg::ResetHeapBase;
            r_init_pages  <= ffha_pkg::ResetInitialPages;
            r_limit_pages <= ffha_pkg::ResetLimitPages;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ffha_pkg::CFG_HEAP_BASE:     r_heap_base   <= i_cfg_data;
                ffha_pkg::CFG_INITIAL_PAGES: r_init_pages  <= i_cfg_data[12:0];
                ffha_pkg::CFG_LIMIT_PAGES:   r_limit_pages <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we    <= 1'b0;
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_count <= '0;
            r_pages <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_we <= i_valid && (i_mode == ffha_pkg::MODE_INIT);
                    if (i_valid) begin
                        r_mode   <= i_mode;
                        r_addr   <= '0;
                        r_status <= ffha_pkg::ST_OK;
                        r_grown  <= 1'b0;
                        r_idx    <= '0;
                        r_want   <= ({7'd0, i_request_size} + 32'(ALIGN_BYTES - 1))
                                    >> ASH << ASH;
                        r_arg    <= (i_mode == ffha_pkg::MODE_FREE) ? i_free_address
                                    : {7'd0, i_request_size};
                        if (i_mode == ffha_pkg::MODE_INIT) begin
                            r_pages <= ipages;
                            r_count <= CW'(1);
                            r_ready <= 1'b1;
                            r_wa    <= '0;
                            r_wd    <= {32'd0, ({19'd0, ipages} << PSH) - Hdr, 1'b0};
                            r_state <= S_DONE;
                        end else if (!r_ready) begin
                            r_status <= ffha_pkg::ST_NOT_READY;
                            r_state  <= S_OUT;
                        end else if (i_mode == ffha_pkg::MODE_ALLOC) begin
                            if (i_request_size == 25'd0) begin
                                r_status <= ffha_pkg::ST_ZERO_SIZE;
                                r_state  <= S_DONE;
                            end else begin
                                r_ra    <= '0;
                                r_state <= S_FRD;
                            end
                        end else if (i_mode == ffha_pkg::MODE_FREE) begin
                            r_ra    <= '0;
                            r_state <= S_DRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FRD: begin
                    r_we    <= 1'b0;
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    r_we <= 1'b0;
                    if (!rd_used && rd_size >= r_want) begin
                        r_ent   <= r_rd;
                        r_state <= S_SPLIT;
                    end else if (r_idx + CW'(1) < r_count) begin
                        r_idx   <= r_idx + CW'(1);
                        r_ra    <= IW'(r_idx + CW'(1));
                        r_state <= S_FRD;
                    end else if (r_grown) begin
                        r_status <= ffha_pkg::ST_NO_MEMORY;
                        r_state  <= S_DONE;
                    end else begin
                        r_ent   <= r_rd;
                        r_state <= S_GROW;
                    end
                end
                S_GROW: begin
                    // r_ent holds the last entry
                    if (g_pages > {19'd0, cap} || {19'd0, r_pages} > {19'd0, cap} - g_pages
                        || (r_ent[0] && r_count >= MaxCnt)) begin
                        r_we     <= 1'b0;
                        r_status <= ffha_pkg::ST_NO_MEMORY;
                        r_state  <= S_DONE;
                    end else begin
                        r_we <= 1'b1;
                        if (!r_ent[0]) begin
                            r_wa <= IW'(r_count - CW'(1));
                            r_wd <= {r_ent[64:33], r_ent[32:1] + (g_pages << PSH), 1'b0};
                        end else begin
                            r_wa    <= IW'(r_count);
                            r_wd    <= {{19'd0, r_pages} << PSH, (g_pages << PSH) - Hdr, 1'b0};
                            r_count <= r_count + CW'(1);
                        end
                        r_pages <= r_pages + g_pages[12:0];
                        r_grown <= 1'b1;
                        r_idx   <= '0;
                        r_ra    <= '0;
                        r_state <= S_GRD;
                    end
                end
                S_GRD: begin
                    r_we    <= 1'b0;
                    r_state <= S_FRD;
                end
                S_SPLIT: begin
                    r_addr <= r_heap_base + r_ent[64:33] + Hdr;
                    if (r_ent[32:1] > r_want + HdrA && r_count < MaxCnt) begin
                        r_pend  <= {r_ent[64:33] + Hdr + r_want,
                                    r_ent[32:1] - r_want - Hdr, 1'b0};
                        r_we    <= 1'b1;
                        r_wa    <= IW'(r_idx);
                        r_wd    <= {r_ent[64:33], r_want, 1'b1};
                        r_pos   <= r_count;
                        r_after <= r_idx + CW'(1);
                        r_state <= S_SHR;
                        r_ra    <= IW'(r_count - CW'(1));
                    end else begin
                        r_we    <= 1'b1;
                        r_wa    <= IW'(r_idx);
                        r_wd    <= {r_ent[64:1], 1'b1};
                        r_state <= S_DONE;
                    end
                end
                S_SHR: begin
                    if (r_pos == r_after) begin
                        r_we    <= 1'b1;
                        r_wa    <= IW'(r_after);
                        r_wd    <= r_pend;
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_we    <= 1'b0;
                        r_ra    <= IW'(r_pos - CW'(1));
                        r_phase <= 1'b0;
                        r_state <= S_SHW;
                    end
                end
                S_SHW: begin
                    r_phase <= ~r_phase;
                    r_we    <= r_phase;
                    if (r_phase) begin
                        r_wa    <= IW'(r_pos);
                        r_wd    <= r_rd;
                        r_pos   <= r_pos - CW'(1);
                        r_state <= S_SHR;
                    end
                end
                S_DRD: begin
                    r_we    <= 1'b0;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    r_we <= 1'b0;
                    if (r_heap_base + rd_off + Hdr == r_arg) begin
                        if (!rd_used) begin
                            r_status <= ffha_pkg::ST_BAD_FREE;
                            r_state  <= S_DONE;
                        end else begin
                            r_ent   <= {r_rd[64:1], 1'b0};
                            r_state <= S_FREEW;
                        end
                    end else if (r_idx + CW'(1) < r_count) begin
                        r_idx   <= r_idx + CW'(1);
                        r_ra    <= IW'(r_idx + CW'(1));
                        r_state <= S_DRD;
                    end else begin
                        r_status <= ffha_pkg::ST_BAD_FREE;
                        r_state  <= S_DONE;
                    end
                end
                S_FREEW: begin
                    r_we <= 1'b1;
                    r_wa <= IW'(r_idx);
                    r_wd <= r_ent;
                    if (r_idx + CW'(1) < r_count) begin
                        r_ra    <= IW'(r_idx + CW'(1));
                        r_state <= S_NRD;
                    end else begin
                        r_state <= S_PRD;
                        r_ra    <= IW'(r_idx - CW'(1));
                    end
                end
                S_NRD: begin
                    r_we    <= 1'b0;
                    r_state <= S_NCHK;
                end
                S_NCHK: begin
                    r_we <= !rd_used;
                    if (!rd_used) begin
                        r_ent    <= {r_ent[64:33], r_ent[32:1] + Hdr + rd_size, 1'b0};
                        r_wa     <= IW'(r_idx);
                        r_wd     <= {r_ent[64:33], r_ent[32:1] + Hdr + rd_size, 1'b0};
                        r_rm_pos <= r_idx + CW'(1);
                        r_ret    <= S_PRD;
                        r_state  <= S_RMR;
                    end else begin
                        r_state <= S_PRD;
                    end
                    r_ra <= IW'(r_idx - CW'(1));
                end
                S_PRD: begin
                    r_we <= 1'b0;
                    if (r_idx == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ra    <= IW'(r_idx - CW'(1));
                        r_phase <= 1'b0;
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    r_phase <= 1'b1;
                    r_we    <= r_phase && !rd_used;
                    if (r_phase) begin
                        if (!rd_used) begin
                            r_wa     <= IW'(r_idx - CW'(1));
                            r_wd     <= {rd_off, rd_size + Hdr + r_ent[32:1], 1'b0};
                            r_rm_pos <= r_idx;
                            r_ret    <= S_DONE;
                            r_state  <= S_RMR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RMR: begin
                    r_we <= 1'b0;
                    if (r_rm_pos + CW'(1) < r_count) begin
                        r_ra    <= IW'(r_rm_pos + CW'(1));
                        r_phase <= 1'b0;
                        r_state <= S_RMW;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= r_ret;
                    end
                end
                S_RMW: begin
                    r_phase <= 1'b1;
                    r_we    <= r_phase;
                    if (r_phase) begin
                        r_wa     <= IW'(r_rm_pos);
                        r_wd     <= r_rd;
                        r_rm_pos <= r_rm_pos + CW'(1);
                        r_state  <= S_RMR;
                    end
                end
                S_DONE: begin
                    r_we    <= 1'b0;
                    r_pass  <= '0;
                    r_ra    <= '0;
                    r_state <= S_STRD;
                end
                S_STRD: begin
                    r_we <= 1'b0;
                    if (r_pass >= r_count || !r_ready) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STACC;
                    end
                end
                S_STACC: begin
                    r_we    <= 1'b0;
                    r_pass  <= r_pass + CW'(1);
                    r_ra    <= IW'(r_pass + CW'(1));
                    r_state <= S_STRD;
                end
                S_OUT: begin
                    r_we <= 1'b0;
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: begin
                    r_we    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = (r_state == S_OUT);
    assign o_status           = r_status;
    assign o_block_address    = (r_mode == ffha_pkg::MODE_ALLOC &&
                                 r_status == ffha_pkg::ST_OK) ? r_addr : 32'd0;
    assign o_heap_span        = r_ready ? 25'({r_pages, {PSH{1'b0}}}) : 25'd0;
    assign o_free_sum         = fb;
    assign o_used_sum         = ub;
    assign o_free_block_count = fc;
    assign o_used_block_count = uc;
    assign o_largest_free     = big;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while idle");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCnt) else $error("block count past table depth");
    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_ready) |-> (o_status == ffha_pkg::ST_NOT_READY ||
        o_status == ffha_pkg::ST_OK)) else $error("bad status before init");
endmodule

// File: dv/first_fit_heap_allocator_checker.sv
// Allocator checker: predicts each result from the accepted beats and compares it.
module first_fit_heap_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [24:0] i_request_size,
    input  logic [31:0] i_free_address,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [2:0]  o_status,
    input  logic [31:0] o_block_address,
    input  logic [24:0] o_heap_span,
    input  logic [24:0] o_free_sum,
    input  logic [24:0] o_used_sum,
    input  logic [6:0]  o_free_block_count,
    input  logic [6:0]  o_used_block_count,
    input  logic [24:0] o_largest_free,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          fails,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      addr;
        ffha_pkg::t_stats stats;
    } t_answer;

    t_answer answer_q[$];

    logic [31:0] heap_base;
    logic [12:0] init_pages;
    logic [12:0] limit_pages;

    int unsigned blk_off[ffha_pkg::MaxBlocks];
    int unsigned blk_size[ffha_pkg::MaxBlocks];
    bit          blk_used[ffha_pkg::MaxBlocks];
    int unsigned blk_count;
    int unsigned heap_pages;
    bit          heap_ready;

    assign outstanding = answer_q.size();

    function automatic int unsigned page_cap();
        int unsigned c;
        c = limit_pages;
        if (c == 0) c = 1;
        if (c > ffha_pkg::HardPageCap) c = ffha_pkg::HardPageCap;
        if (c > ffha_pkg::HeapMaxBytes / ffha_pkg::PageBytes)
            c = ffha_pkg::HeapMaxBytes / ffha_pkg::PageBytes;
        return c;
    endfunction

    function automatic void blk_insert(int unsigned pos, int unsigned off, int unsigned sz,
                                       bit used);
        for (int unsigned i = blk_count; i > pos; i--) begin
            blk_off[i]  = blk_off[i-1];
            blk_size[i] = blk_size[i-1];
            blk_used[i] = blk_used[i-1];
        end
        blk_off[pos]  = off;
        blk_size[pos] = sz;
        blk_used[pos] = used;
        blk_count++;
    endfunction

    function automatic void blk_remove(int unsigned pos);
        for (int unsigned i = pos; i + 1 < blk_count; i++) begin
            blk_off[i]  = blk_off[i+1];
            blk_size[i] = blk_size[i+1];
            blk_used[i] = blk_used[i+1];
        end
        blk_count--;
    endfunction

    function automatic int unsigned first_fit(int unsigned wanted);
        for (int unsigned i = 0; i < blk_count; i++)
            if (!blk_used[i] && blk_size[i] >= wanted) return i;
        return blk_count;
    endfunction

    function automatic bit heap_grow(int unsigned wanted);
        int unsigned pg;
        int unsigned added;
        pg = (wanted + ffha_pkg::HeaderBytes + ffha_pkg::PageBytes - 1) / ffha_pkg::PageBytes;
        if (blk_count == 0) return 0;
        if (pg > page_cap() || heap_pages > page_cap() - pg) return 0;
        added = pg * ffha_pkg::PageBytes;
        if (!blk_used[blk_count-1]) begin
            blk_size[blk_count-1] += added;
        end else begin
            if (blk_count >= ffha_pkg::MaxBlocks) return 0;
            blk_insert(blk_count, heap_pages * ffha_pkg::PageBytes,
                       added - ffha_pkg::HeaderBytes, 0);
        end
        heap_pages += pg;
        return 1;
    endfunction

    function automatic logic [2:0] heap_alloc(int unsigned sz, output logic [31:0] addr);
        int unsigned wanted;
        int unsigned idx;
        addr = '0;
        if (sz == 0) return ffha_pkg::ST_ZERO_SIZE;
        wanted = ((sz + ffha_pkg::AlignBytes - 1) / ffha_pkg::AlignBytes) * ffha_pkg::AlignBytes;
        idx = first_fit(wanted);
        if (idx >= blk_count) begin
            if (!heap_grow(wanted)) return ffha_pkg::ST_NO_MEMORY;
            idx = first_fit(wanted);
            if (idx >= blk_count) return ffha_pkg::ST_NO_MEMORY;
        end
        if (blk_size[idx] > wanted + ffha_pkg::HeaderBytes + ffha_pkg::AlignBytes &&
            blk_count < ffha_pkg::MaxBlocks) begin
            blk_insert(idx + 1, blk_off[idx] + ffha_pkg::HeaderBytes + wanted,
                       blk_size[idx] - wanted - ffha_pkg::HeaderBytes, 0);
            blk_size[idx] = wanted;
        end
        blk_used[idx] = 1;
        addr = heap_base + blk_off[idx] + ffha_pkg::HeaderBytes;
        return ffha_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] heap_free(logic [31:0] addr);
        int unsigned i;
        for (i = 0; i < blk_count; i++)
            if (heap_base + blk_off[i] + ffha_pkg::HeaderBytes == addr) break;
        if (i >= blk_count || !blk_used[i]) return ffha_pkg::ST_BAD_FREE;
        blk_used[i] = 0;
        if (i + 1 < blk_count && !blk_used[i+1]) begin
            blk_size[i] += ffha_pkg::HeaderBytes + blk_size[i+1];
            blk_remove(i + 1);
        end
        if (i > 0 && !blk_used[i-1]) begin
            blk_size[i-1] += ffha_pkg::HeaderBytes + blk_size[i];
            blk_remove(i);
        end
        return ffha_pkg::ST_OK;
    endfunction

    function automatic t_answer predict_answer(logic [1:0] mode, logic [24:0] sz,
                                               logic [31:0] faddr);
        t_answer a;
        int unsigned pg, fb, ub, fc, uc, big;
        a = '0;
        fb = 0; ub = 0; fc = 0; uc = 0; big = 0;
        if (mode == ffha_pkg::MODE_INIT) begin
            pg = init_pages;
            if (pg == 0) pg = 1;
            if (pg > page_cap()) pg = page_cap();
            heap_pages = pg;
            blk_count  = 0;
            blk_insert(0, 0, pg * ffha_pkg::PageBytes - ffha_pkg::HeaderBytes, 0);
            heap_ready = 1;
        end else if (!heap_ready) begin
            a.status = ffha_pkg::ST_NOT_READY;
        end else if (mode == ffha_pkg::MODE_ALLOC) begin
            a.status = heap_alloc(sz, a.addr);
        end else if (mode == ffha_pkg::MODE_FREE) begin
            a.status = heap_free(faddr);
        end
        if (heap_ready) begin
            for (int unsigned i = 0; i < blk_count; i++) begin
                if (blk_used[i]) begin
                    ub += blk_size[i];
                    uc++;
                end else begin
                    fb += blk_size[i];
                    fc++;
                    if (blk_size[i] > big) big = blk_size[i];
                end
            end
            a.stats.heap_span = 25'(heap_pages * ffha_pkg::PageBytes);
        end
        a.stats.free_sum     = 25'(fb);
        a.stats.used_sum     = 25'(ub);
        a.stats.free_count   = 7'(fc > 127 ? 127 : fc);
        a.stats.used_count   = 7'(uc > 127 ? 127 : uc);
        a.stats.largest_free = 25'(big);
        return a;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            fails++;
            if (fails <= 10)
                $display("%t mismatch %s: expected %h actual %h", $realtime, name, exp, act);
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            heap_base   <= ffha_pkg::ResetHeapBase;
            init_pages  <= ffha_pkg::ResetInitialPages;
            limit_pages <= ffha_pkg::ResetLimitPages;
            blk_count   = 0;
            heap_pages  = 0;
            heap_ready  = 0;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ffha_pkg::CFG_HEAP_BASE:     heap_base   <= i_cfg_data;
                    ffha_pkg::CFG_INITIAL_PAGES: init_pages  <= i_cfg_data[12:0];
                    ffha_pkg::CFG_LIMIT_PAGES:   limit_pages <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                answer_q.push_back(predict_answer(i_mode, i_request_size, i_free_address));
            if (o_valid && !i_stall) begin
                if (answer_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("%t result beat with nothing expected", $realtime);
                end else begin
                    e = answer_q.pop_front();
                    check_field("status", e.status, o_status);
                    check_field("block_address", e.addr, o_block_address);
                    check_field("heap_span", e.stats.heap_span, o_heap_span);
                    check_field("free_sum", e.stats.free_sum, o_free_sum);
                    check_field("used_sum", e.stats.used_sum, o_used_sum);
                    check_field("free_block_count", e.stats.free_count, o_free_block_count);
                    check_field("used_block_count", e.stats.used_count, o_used_block_count);
                    check_field("largest_free", e.stats.largest_free, o_largest_free);
                end
            end
        end
    end
endmodule

// File: dv/first_fit_heap_allocator_test.sv
// Allocator testbench top: clock, reset, stimulus, idling, output stalls and the verdict.
module first_fit_heap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_mode = ffha_pkg::MODE_STATS;
    logic [24:0] i_request_size = '0;
    logic [31:0] i_free_address = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [31:0] o_block_address;
    logic [24:0] o_heap_span, o_free_sum, o_used_sum, o_largest_free;
    logic [6:0]  o_free_block_count, o_used_block_count;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = ffha_pkg::CFG_HEAP_BASE;
    logic [31:0] i_cfg_data = '0;

    int fails, outstanding;
    int idle_pct = 0, stall_pct = 0;
    int sent = 0, got = 0;
    logic [31:0] live_q[$];

    first_fit_heap_allocator dut (.*);

    first_fit_heap_allocator_checker checker_i (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk)
        if (o_valid && !i_stall) begin
            got++;
            if (o_status == ffha_pkg::ST_OK && o_block_address != 0)
                live_q.push_back(o_block_address);
        end

    task automatic send_beat(logic [1:0] mode, logic [24:0] sz, logic [31:0] faddr);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        if (mode == ffha_pkg::MODE_INIT) live_q.delete();
        i_valid        <= 1;
        i_mode         <= mode;
        i_request_size <= sz;
        i_free_address <= faddr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (got != sent) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] take_live(bit keep);
        int k;
        logic [31:0] a;
        k = $urandom_range(live_q.size() - 1);
        a = live_q[k];
        if (!keep) live_q.delete(k);
        return a;
    endfunction

    task automatic random_beat();
        int r, s;
        logic [24:0] sz;
        logic [31:0] fa;
        r  = $urandom_range(99);
        s  = $urandom_range(99);
        sz = 25'($urandom);
        fa = $urandom;
        if (r < 2) begin
            send_beat(ffha_pkg::MODE_INIT, sz, fa);
        end else if (r < 8) begin
            send_beat(ffha_pkg::MODE_STATS, sz, fa);
        end else if (r < 63) begin
            if (s < 70) sz = 25'($urandom_range(256, 1));
            else if (s < 85) sz = 25'($urandom_range(8192, 257));
            else if (s < 94) sz = 25'($urandom_range(70000, 8193));
            else if (s < 97) sz = '0;
            else sz = 25'($urandom_range(16777216, 1 << 20));
            send_beat(ffha_pkg::MODE_ALLOC, sz, fa);
        end else begin
            if (live_q.size() != 0 && s < 80) fa = take_live(0);
            else if (live_q.size() != 0 && s < 90) fa = take_live(1) + 32'd16;
            else if (live_q.size() != 0 && s < 95) fa = take_live(1);
            send_beat(ffha_pkg::MODE_FREE, sz, fa);
        end
    endtask

    initial begin
        logic [31:0] a;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_beat(ffha_pkg::MODE_STATS, 25'h1FFFFFF, 32'hFFFF_FFFF);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd16, 32'd0);
        send_beat(ffha_pkg::MODE_FREE, 25'd0, ffha_pkg::ResetHeapBase + 32'd16);
        send_beat(ffha_pkg::MODE_INIT, 25'd0, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd0, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd1, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd16, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd17, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd16777216, 32'd0);
        send_beat(ffha_pkg::MODE_FREE, 25'd0, 32'd0);
        drain();
        a = live_q[1];
        send_beat(ffha_pkg::MODE_FREE, 25'd0, a);
        send_beat(ffha_pkg::MODE_FREE, 25'd0, a);
        send_beat(ffha_pkg::MODE_FREE, 25'd0, live_q[0]);
        send_beat(ffha_pkg::MODE_FREE, 25'd0, live_q[2]);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd20000, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd32, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd8000, 32'd0);
        send_beat(ffha_pkg::MODE_ALLOC, 25'd16777200, 32'd0);
        send_beat(ffha_pkg::MODE_STATS, 25'd0, 32'd0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p % 5)
                0: begin
                    cfg_write(ffha_pkg::CFG_HEAP_BASE, ffha_pkg::ResetHeapBase);
                    cfg_write(ffha_pkg::CFG_INITIAL_PAGES, 32'd4);
                    cfg_write(ffha_pkg::CFG_LIMIT_PAGES, 32'd4096);
                end
                1: begin
                    cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'd0);
                    cfg_write(ffha_pkg::CFG_INITIAL_PAGES, 32'd1);
                    cfg_write(ffha_pkg::CFG_LIMIT_PAGES, 32'd1);
                end
                2: begin
                    cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF0);
                    cfg_write(ffha_pkg::CFG_INITIAL_PAGES, 32'd4096);
                    cfg_write(ffha_pkg::CFG_LIMIT_PAGES, 32'd4096);
                end
                3: begin
                    cfg_write(ffha_pkg::CFG_HEAP_BASE, $urandom);
                    cfg_write(ffha_pkg::CFG_INITIAL_PAGES, 32'd8);
                    cfg_write(ffha_pkg::CFG_LIMIT_PAGES, 32'd2);
                end
                default: begin
                    cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_0000);
                    cfg_write(ffha_pkg::CFG_INITIAL_PAGES, 32'd2);
                    cfg_write(ffha_pkg::CFG_LIMIT_PAGES, 32'd16);
                end
            endcase
            i_cfg_valid <= 0;
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            send_beat(ffha_pkg::MODE_INIT, 25'($urandom), $urandom);
            repeat (229) random_beat();
            drain();
        end

        if (fails == 0 && outstanding == 0)
            $display("first_fit_heap_allocator_test: clean");
        else
            $display("first_fit_heap_allocator_test: errors");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("first_fit_heap_allocator_test: errors");
        $finish;
    end
endmodule
